[hw/rtl/lkt_pkg.sv]
// lkt_pkg: sizes, register map and helper functions for the lru key tracker
// no dependencies; imported by every other file of the block

package lkt_pkg;

  // storage sizes
  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W    = $clog2(DEPTH + 1);

  // port field widths
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  // register map
  localparam int         REG_MAX_ENTRIES = 0;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(16);

  typedef logic [KEY_BITS-1:0] key_t;

  // per-cell control
  typedef struct packed {
    logic shift;  // take the neighbor's key this cycle
    logic live;   // cell position lies below the occupied count
  } lkt_cell_ctrl_t;

  // low key bits kept in storage
  function automatic key_t key_trim(input logic [KEY_W-1:0] k);
    logic [63:0] t;
    t = 64'(k);
    return t[KEY_BITS-1:0];
  endfunction

  // stored key widened or cut to the port width
  function automatic logic [KEY_W-1:0] key_out(input key_t k);
    logic [63:0] t;
    t = 64'(k);
    return t[KEY_W-1:0];
  endfunction

endpackage

[hw/rtl/lkt_in_if.sv]
// lkt_in_if: request channel carrying one key per word
// depends on lkt_pkg

interface lkt_in_if;
  import lkt_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
  modport monitor (input valid, input key, input ready);
endinterface

[hw/rtl/lkt_out_if.sv]
// lkt_out_if: result channel, one word per request
// depends on lkt_pkg

interface lkt_out_if;
  import lkt_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] access_total;

  modport source (output valid, output hit, output evicted, output evicted_key,
                  output miss_total, output access_total, input ready);
  modport sink (input valid, input hit, input evicted, input evicted_key,
                input miss_total, input access_total, output ready);
  modport monitor (input valid, input hit, input evicted, input evicted_key,
                   input miss_total, input access_total, input ready);
endinterface

[hw/rtl/lkt_cell.sv]
// lkt_cell: one position of the recency stack, holds a key and compares it
// depends on lkt_pkg

module lkt_cell (
  input  logic                    clk_i,
  input  lkt_pkg::lkt_cell_ctrl_t ctrl_i,
  input  lkt_pkg::key_t           lookup_i,
  input  lkt_pkg::key_t           prev_key_i,
  output lkt_pkg::key_t           key_o,
  output logic                    match_o
);
  import lkt_pkg::*;

  key_t key_q;

  // shift in from the neighbor closer to the front
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q <= prev_key_i;
    end
  end

  // compare only while the position is occupied
  assign match_o = ctrl_i.live && (key_q == lookup_i);
  assign key_o   = key_q;

endmodule

[hw/rtl/lkt_cfg_regs.sv]
// lkt_cfg_regs: apb register file holding the entry limit
// depends on lkt_pkg

module lkt_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkt_pkg::APB_AW-1:0] paddr,
  input  logic [lkt_pkg::APB_DW-1:0] pwdata,
  output logic [lkt_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [lkt_pkg::OCC_W-1:0]  limit_o
);
  import lkt_pkg::*;

  logic [CFG_W-1:0] max_entries_q;
  logic             wr_en;
  logic             sel_max;

  assign sel_max = (int'(paddr >> 2) == REG_MAX_ENTRIES);
  assign wr_en   = psel && penable && pwrite && sel_max;
  assign pready  = 1'b1;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
    end else if (wr_en) begin
      max_entries_q <= pwdata[CFG_W-1:0];
    end
  end

  // read back
  assign prdata = sel_max ? APB_DW'(max_entries_q) : '0;

  // zero acts as one, values above the depth saturate
  always_comb begin
    if (max_entries_q == '0) begin
      limit_o = OCC_W'(1);
    end else if (int'(max_entries_q) > DEPTH) begin
      limit_o = OCC_W'(DEPTH);
    end else begin
      limit_o = OCC_W'(max_entries_q);
    end
  end

endmodule

[hw/rtl/lru_key_tracker.sv]
// lru_key_tracker: top level, row of recency cells plus control and result register
// depends on lkt_pkg, lkt_in_if, lkt_out_if, lkt_cell, lkt_cfg_regs

// Usage
//   in_i carries one key per word; out_o returns one result word per key
//   (hit, evicted, evicted_key, miss_total, access_total).
//   Every key is compared against all 16 cells at once; on a hit the key
//   moves to the front, on a miss the last key may be evicted and the new
//   key is pushed in at the front. Cells shift toward the back together.
//   A result is registered and valid in the cycle after its key is accepted,
//   and one key is taken every cycle while out_o does not stall; the compare
//   and shift across the cell row set that rate.
//   When out_o stalls, the result is held and a new key is taken only in a
//   cycle where the held result leaves.
//   The apb port writes max_entries at address 0; the user must do so only
//   while the block is idle, which the block does not enforce. Reset empties the stack,
//   clears both counters and sets max_entries to 16; no clearing pass is needed.

module lru_key_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lkt_in_if.sink                     in_i,
  lkt_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkt_pkg::APB_AW-1:0] paddr,
  input  logic [lkt_pkg::APB_DW-1:0] pwdata,
  output logic [lkt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import lkt_pkg::*;

  logic [OCC_W-1:0] limit;
  logic [OCC_W-1:0] occ_q, occ_d, occ_kept;
  logic [CNT_W-1:0] miss_q, access_q, miss_d, access_d;
  logic             accept;
  logic             hit, drop;
  logic [IDX_W-1:0] pos, upto, bound, last_idx;
  key_t             lookup;
  key_t             cell_key [DEPTH];
  key_t             prev_key [DEPTH];
  logic [DEPTH-1:0] match;
  lkt_cell_ctrl_t   ctrl [DEPTH];

  logic             out_valid_q;
  logic             hit_q, evicted_q;
  logic [KEY_W-1:0] evicted_key_q;

  // configuration
  lkt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // handshake: the result register frees as it is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign lookup     = key_trim(in_i.key);

  // row of cells, cell zero loads the incoming key
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_front
      assign prev_key[j] = lookup;
    end else begin : g_body
      assign prev_key[j] = cell_key[j-1];
    end

    assign ctrl[j].shift = accept && (int'(bound) >= j);
    assign ctrl[j].live  = (int'(occ_q) > j);

    lkt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[j]),
      .lookup_i   (lookup),
      .prev_key_i (prev_key[j]),
      .key_o      (cell_key[j]),
      .match_o    (match[j])
    );
  end

  // first matching position
  always_comb begin
    pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = IDX_W'(i);
      end
    end
  end

  // hit, eviction and shift boundary
  always_comb begin
    hit      = |match;
    drop     = !hit && (occ_q >= limit) && (occ_q != '0);
    occ_kept = drop ? (occ_q - OCC_W'(1)) : occ_q;
    last_idx = IDX_W'(occ_q - OCC_W'(1));
    if (int'(occ_kept) >= DEPTH - 1) begin
      upto = IDX_W'(DEPTH - 1);
    end else begin
      upto = IDX_W'(occ_kept);
    end
    bound = hit ? pos : upto;
    if (hit || int'(occ_kept) >= DEPTH) begin
      occ_d = occ_kept;
    end else begin
      occ_d = occ_kept + OCC_W'(1);
    end
    access_d = access_q + CNT_W'(1);
    miss_d   = hit ? miss_q : (miss_q + CNT_W'(1));
  end

  // occupancy and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      miss_q   <= '0;
      access_q <= '0;
    end else if (accept) begin
      occ_q    <= occ_d;
      miss_q   <= miss_d;
      access_q <= access_d;
    end
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q         <= hit;
      evicted_q     <= drop;
      evicted_key_q <= drop ? key_out(cell_key[last_idx]) : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = hit_q;
  assign out_o.evicted      = evicted_q;
  assign out_o.evicted_key  = evicted_key_q;
  assign out_o.miss_total   = miss_q;
  assign out_o.access_total = access_q;

endmodule

[hw/rtl/lkt_checker.sv]
// lkt_checker: port-level assertions for lru_key_tracker, bound to the top level
// depends on lkt_pkg, lkt_in_if, lkt_out_if, lru_key_tracker

module lkt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_hit_i,
  input logic                      out_evicted_i,
  input logic [lkt_pkg::KEY_W-1:0] out_evicted_key_i,
  input logic [lkt_pkg::CNT_W-1:0] out_access_total_i
);
  import lkt_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_access_total_i)
      && $stable(out_evicted_key_i))
    else $error("stalled result word changed");

  // an accepted key yields a result word next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted key gave no result word");

  // a new key is taken only when the held result leaves
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("key taken while result word stalled");

  // a hit never evicts, and no eviction means a zero key
  a_evict_rules: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_hit_i || !out_evicted_i) |-> out_evicted_key_i == '0
      && !(out_hit_i && out_evicted_i))
    else $error("eviction fields inconsistent");

endmodule

bind lru_key_tracker lkt_checker u_lkt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_hit_i          (out_o.hit),
  .out_evicted_i      (out_o.evicted),
  .out_evicted_key_i  (out_o.evicted_key),
  .out_access_total_i (out_o.access_total)
);

[dv/lkt_lookup_checker.sv]
`timescale 1ns / 100ps
// lkt_lookup_checker: watches the key and result channels and the apb port of
// the lru key tracker, predicts every result word and compares it in order
// depends on lkt_pkg, lkt_in_if and lkt_out_if

module lkt_lookup_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lkt_in_if.monitor                  req_i,
  lkt_out_if.monitor                 res_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkt_pkg::APB_AW-1:0] paddr,
  input  logic [lkt_pkg::APB_DW-1:0] pwdata,
  input  logic                       pready,
  output int                         err_count_o,
  output int                         pending_o
);
  import lkt_pkg::*;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] access_total;
  } lookup_result_t;

  // shadow of the recency stack, front at index 0
  key_t             mru_keys [DEPTH];
  int               held;
  logic [CNT_W-1:0] misses;
  logic [CNT_W-1:0] accesses;
  logic [CFG_W-1:0] limit_reg;
  int               errors;

  lookup_result_t expected_lookups [$];

  assign err_count_o = errors;

  // one lookup: find the key, evict the back entry on a full miss, push to front
  function automatic lookup_result_t predict_lookup(input logic [KEY_W-1:0] raw);
    lookup_result_t r;
    key_t           k;
    int             pos;
    int             lim;
    int             last;
    bit             found;
    k     = key_t'(raw);
    r     = '0;
    pos   = 0;
    found = 1'b0;
    accesses = accesses + 1'b1;
    for (int i = 0; i < held; i++) begin
      if (!found && mru_keys[i] == k) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      last = pos;
    end else begin
      misses = misses + 1'b1;
      // zero acts as one, anything above the depth saturates
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      // a lowered limit still drops only the single back entry
      if (held >= lim && held > 0) begin
        r.evicted     = 1'b1;
        r.evicted_key = KEY_W'(mru_keys[held-1]);
        held          = held - 1;
      end
      last = held;
      if (held < DEPTH) held = held + 1;
    end
    if (last > DEPTH - 1) last = DEPTH - 1;
    for (int i = last; i > 0; i--) mru_keys[i] = mru_keys[i-1];
    mru_keys[0]    = k;
    r.hit          = found;
    r.miss_total   = misses;
    r.access_total = accesses;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  // compare results, track the limit register, predict accepted keys
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      held      = 0;
      misses    = '0;
      accesses  = '0;
      limit_reg = MAX_ENTRIES_RST;
      errors    = 0;
      expected_lookups.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result word with no lookup waiting, expected none, actual %h",
                   $time, {res_i.hit, res_i.evicted, res_i.evicted_key});
          errors++;
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", CNT_W'(want.hit), CNT_W'(res_i.hit));
          check_field("evicted", CNT_W'(want.evicted), CNT_W'(res_i.evicted));
          check_field("evicted_key", CNT_W'(want.evicted_key), CNT_W'(res_i.evicted_key));
          check_field("miss_total", want.miss_total, res_i.miss_total);
          check_field("access_total", want.access_total, res_i.access_total);
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr == APB_AW'(4 * REG_MAX_ENTRIES)) begin
        limit_reg = pwdata[CFG_W-1:0];
      end
      if (req_i.valid && req_i.ready) begin
        expected_lookups.push_back(predict_lookup(req_i.key));
      end
      pending_o <= expected_lookups.size();
    end
  end

endmodule

[dv/tb_lru_key_tracker.sv]
`timescale 1ns / 100ps
// tb_lru_key_tracker: drives keys, result back-pressure and limit writes into
// the lru key tracker; lkt_lookup_checker predicts and compares the results
// depends on lkt_pkg, lkt_in_if, lkt_out_if, lru_key_tracker, lkt_lookup_checker

module tb_lru_key_tracker;
  import lkt_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int err_count;
  int pending;
  int taken;
  bit steady_src;

  lkt_in_if  req_ch ();
  lkt_out_if res_ch ();

  lru_key_tracker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lkt_lookup_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .res_i       (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one key and hold it until the word is taken
  task automatic send_key(input logic [KEY_W-1:0] k);
    int gap;
    gap = steady_src ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.key   <= k;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // stop offering and wait until every result word has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // setup and access cycle; upper data bits are junk the block must drop
  task automatic apb_write(input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * REG_MAX_ENTRIES);
    pwdata  <= ($urandom() & ~APB_DW'(32'h1f)) | APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic tick_out();
    @(posedge clk_i);
    if (res_ch.valid && res_ch.ready) taken++;
  endtask

  // result side: random stalls and one long hold-off so the input backs up
  initial begin
    int  stall;
    bit  held_off;
    held_off     = 1'b0;
    taken        = 0;
    res_ch.ready = 1'b0;
    forever begin
      if (taken >= 400 && !held_off) begin
        held_off = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (300) tick_out();
      end
      stall = gap_len();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) tick_out();
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 100 : 8)) tick_out();
    end
  end

  // stimulus
  initial begin
    int               pool_n;
    int               sel;
    logic [KEY_W-1:0] k;
    logic [CFG_W-1:0] lim_plan [8];
    logic [KEY_W-1:0] key_pool [$];
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.key   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady_src   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limit zero behaves as one: every new key pushes out the previous one
    apb_write(CFG_W'(0));
    send_key('0);
    send_key('1);
    send_key('1);
    send_key('0);
    drain();

    // limit above depth saturates: fill all cells, hit the back, then evict
    apb_write(CFG_W'(31));
    for (int i = 1; i <= 15; i++) send_key({16'(i), ~16'(i)});
    send_key('0);
    send_key('1);
    drain();

    // limit lowered under the occupancy: a miss drops one, a hit drops none
    apb_write(CFG_W'(3));
    send_key(32'h8000_0001);
    send_key({16'(3), ~16'(3)});

    // random phases, each with its own limit and pool of recurring keys
    lim_plan = '{CFG_W'(16), CFG_W'(0), CFG_W'(31), CFG_W'(1),
                 CFG_W'($urandom_range(0, 31)), CFG_W'(8),
                 CFG_W'($urandom_range(0, 31)), CFG_W'(16)};
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      apb_write(lim_plan[ph]);
      steady_src = ($urandom_range(0, 3) == 0);
      key_pool.delete();
      pool_n = $urandom_range(4, 28);
      repeat (pool_n) key_pool.push_back($urandom());
      repeat (222) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
        else if (sel < 88) k = '0;
        else if (sel < 91) k = '1;
        else k = $urandom();
        send_key(k);
      end
    end
    drain();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
